@@ hw/rtl/nnsa_pkg.sv @@
package nnsa_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_DIM   = 4096;

	localparam int DIM_W     = 13;
	localparam int ORG_W     = 12;
	localparam int IDX_W     = 24;
	localparam int ACC_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int AXES      = 2;
	localparam int INT_W     = ACC_W - FRAC_BITS;
	localparam int MUL_A_W   = (INT_W > DIM_W) ? INT_W : DIM_W;
	localparam int DIV_CNT_W = $clog2(FRAC_BITS);

	localparam logic [DIM_W-1:0] SCREEN_PITCH_RST = DIM_W'(1024);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOURCE_WIDTH      = 3'd0,
		CFG_SOURCE_HEIGHT     = 3'd1,
		CFG_SOURCE_ROW_PITCH  = 3'd2,
		CFG_TARGET_WIDTH      = 3'd3,
		CFG_TARGET_HEIGHT     = 3'd4,
		CFG_TARGET_ROW_ORIGIN = 3'd5,
		CFG_TARGET_COL_ORIGIN = 3'd6,
		CFG_SCREEN_PITCH      = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_COPY  = 2'd1,
		MODE_SCALE = 2'd2
	} walk_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_DIV  = 2'd1,
		ST_EMIT = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		logic begin_walk;
		logic div_start;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic scale_req;
		logic div_done;
	} sts_t;

	function automatic logic dim_ok(input logic [DIM_W-1:0] d);
		return (d != '0) && (32'(d) <= MAX_DIM);
	endfunction

endpackage

@@ hw/rtl/nnsa_ifs.sv @@
interface nnsa_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source(output valid, output restart, input ready);
	modport sink(input valid, input restart, output ready);
endinterface

interface nnsa_res_if;
	import nnsa_pkg::*;

	logic             valid;
	logic             ready;
	logic             pixel_valid;
	logic [IDX_W-1:0] source_index;
	logic [IDX_W-1:0] dest_index;
	logic             row_end;
	logic             frame_end;

	modport source(output valid, output pixel_valid, output source_index, output dest_index,
		output row_end, output frame_end, input ready);
	modport sink(input valid, input pixel_valid, input source_index, input dest_index,
		input row_end, input frame_end, output ready);
endinterface

@@ hw/rtl/nearest_neighbour_scale_addresser.sv @@
// Channel   Direction  Payload
// req       in         restart
// res       out        pixel_valid, source_index, dest_index, row_end, frame_end
// cfg       in         cfg_write, cfg_index, cfg_data (eight registers, no read-back)
//
// An item without restart is accepted in ST_IDLE and then loads the result register in
// ST_EMIT. A restart into scaling first waits in ST_DIV for the radix-2 step division,
// which runs both axes in parallel, one quotient bit per cycle.
// Reset leaves the walk idle and the screen pitch at 1024.
// A result waiting in the output register does not block the next item from being
// accepted; only the following result waits for it to be taken.
module nearest_neighbour_scale_addresser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [nnsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nnsa_pkg::DIM_W-1:0]     cfg_data,
	nnsa_req_if.sink                       req,
	nnsa_res_if.source                     res
);
	import nnsa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	nnsa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_restart(req.restart),
		.req_ready  (req.ready),
		.res_ready  (res.ready),
		.res_valid  (res.valid),
		.sts        (sts),
		.cmd        (cmd)
	);

	nnsa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.sts         (sts),
		.pixel_valid (res.pixel_valid),
		.source_index(res.source_index),
		.dest_index  (res.dest_index),
		.row_end     (res.row_end),
		.frame_end   (res.frame_end)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!res.valid || res.ready))
		else $error("result register loaded while a result was still waiting");

	a_div_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(u_ctrl.state_q == ST_DIV) |-> !req.ready)
		else $error("input taken while the step division runs");

	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.frame_end) |-> res.row_end)
		else $error("frame end without row end");

	a_blank_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.pixel_valid) |-> (res.source_index == '0 && res.dest_index == '0
			&& !res.row_end && !res.frame_end))
		else $error("result without a pixel carries nonzero fields");

	a_emit_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !cmd.emit)
		else $error("result produced before the step division finished");
endmodule

@@ hw/rtl/nnsa_div.sv @@
module nnsa_div (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [nnsa_pkg::AXES-1:0][nnsa_pkg::DIM_W-1:0]     num,
	input  logic [nnsa_pkg::AXES-1:0][nnsa_pkg::DIM_W-1:0]     den,
	output logic [nnsa_pkg::AXES-1:0][nnsa_pkg::FRAC_BITS-1:0] quot,
	output logic                                        done
);
	import nnsa_pkg::*;

	logic                                 busy_q;
	logic                                 done_q;
	logic [DIV_CNT_W-1:0]                 cnt_q;
	logic [AXES-1:0][DIM_W-1:0]           rem_q;
	logic [AXES-1:0][DIM_W-1:0]           den_q;
	logic [AXES-1:0][FRAC_BITS-1:0]       quot_q;
	logic [AXES-1:0][DIM_W:0]             trial;
	logic [AXES-1:0]                      fits;

	// One quotient bit per cycle on each axis; the numerator is below the
	// divisor, so the remainder always stays within the divisor's width.
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			trial[i] = {rem_q[i], 1'b0};
			fits[i]  = trial[i] >= {1'b0, den_q[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(FRAC_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			if (start) begin
				rem_q[i]  <= num[i];
				den_q[i]  <= den[i];
				quot_q[i] <= '0;
			end else if (busy_q) begin
				if (fits[i]) begin
					rem_q[i] <= DIM_W'(trial[i] - {1'b0, den_q[i]});
				end else begin
					rem_q[i] <= trial[i][DIM_W-1:0];
				end
				quot_q[i] <= {quot_q[i][FRAC_BITS-2:0], fits[i]};
			end
		end
	end

	assign quot = quot_q;
	assign done = done_q;
endmodule

@@ hw/rtl/nnsa_dp.sv @@
module nnsa_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [nnsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nnsa_pkg::DIM_W-1:0]      cfg_data,
	input  nnsa_pkg::cmd_t                  cmd,
	output nnsa_pkg::sts_t                  sts,
	output logic                            pixel_valid,
	output logic [nnsa_pkg::IDX_W-1:0]      source_index,
	output logic [nnsa_pkg::IDX_W-1:0]      dest_index,
	output logic                            row_end,
	output logic                            frame_end
);
	import nnsa_pkg::*;

	logic [DIM_W-1:0] src_w_q, src_h_q, src_pitch_q, tgt_w_q, tgt_h_q, scr_pitch_q;
	logic [ORG_W-1:0] org_row_q, org_col_q;

	walk_mode_t           mode_q;
	walk_mode_t           mode_dec;
	logic [DIM_W-1:0]     col_q, row_q;
	logic [ACC_W-1:0]     xacc_q, yacc_q;
	logic [FRAC_BITS-1:0] stepx_q, stepy_q;

	logic [AXES-1:0][DIM_W-1:0]     div_num, div_den;
	logic [AXES-1:0][FRAC_BITS-1:0] div_quot;
	logic                           div_done;

	logic                         is_copy;
	logic [MUL_A_W-1:0]           src_a;
	logic [DIM_W-1:0]             src_b;
	logic [MUL_A_W+DIM_W-1:0]     src_prod;
	logic [IDX_W-1:0]             src_sum;
	logic [DIM_W:0]               dst_row;
	logic [2*DIM_W:0]             dst_prod;
	logic [IDX_W-1:0]             dst_sum;
	logic                         last_col, last_row;

	logic             pix_q, rend_q, fend_q;
	logic [IDX_W-1:0] src_idx_q, dst_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q     <= '0;
			src_h_q     <= '0;
			src_pitch_q <= '0;
			tgt_w_q     <= '0;
			tgt_h_q     <= '0;
			org_row_q   <= '0;
			org_col_q   <= '0;
			scr_pitch_q <= SCREEN_PITCH_RST;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SOURCE_WIDTH:      src_w_q     <= cfg_data;
				CFG_SOURCE_HEIGHT:     src_h_q     <= cfg_data;
				CFG_SOURCE_ROW_PITCH:  src_pitch_q <= cfg_data;
				CFG_TARGET_WIDTH:      tgt_w_q     <= cfg_data;
				CFG_TARGET_HEIGHT:     tgt_h_q     <= cfg_data;
				CFG_TARGET_ROW_ORIGIN: org_row_q   <= cfg_data[ORG_W-1:0];
				CFG_TARGET_COL_ORIGIN: org_col_q   <= cfg_data[ORG_W-1:0];
				CFG_SCREEN_PITCH:      scr_pitch_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		mode_dec = MODE_IDLE;
		if (dim_ok(src_w_q) && dim_ok(src_h_q) && dim_ok(tgt_w_q) && dim_ok(tgt_h_q)) begin
			if (src_w_q == tgt_w_q && src_h_q == tgt_h_q) begin
				mode_dec = MODE_COPY;
			end else if (src_w_q < tgt_w_q && src_h_q < tgt_h_q) begin
				mode_dec = MODE_SCALE;
			end
		end
	end

	assign div_num = {src_h_q, src_w_q};
	assign div_den = {tgt_h_q, tgt_w_q};

	nnsa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.quot  (div_quot),
		.done  (div_done)
	);

	assign sts.scale_req = (mode_dec == MODE_SCALE);
	assign sts.div_done  = div_done;

	assign is_copy  = (mode_q == MODE_COPY);
	assign src_a    = is_copy ? MUL_A_W'(row_q) : MUL_A_W'(yacc_q[ACC_W-1:FRAC_BITS]);
	assign src_b    = is_copy ? tgt_w_q : src_pitch_q;
	assign src_prod = (MUL_A_W+DIM_W)'(src_a) * (MUL_A_W+DIM_W)'(src_b);
	assign src_sum  = IDX_W'(src_prod)
		+ (is_copy ? IDX_W'(col_q) : IDX_W'(xacc_q[ACC_W-1:FRAC_BITS]));

	assign dst_row  = (DIM_W+1)'(org_row_q) + (DIM_W+1)'(row_q);
	assign dst_prod = (2*DIM_W+1)'(dst_row) * (2*DIM_W+1)'(scr_pitch_q);
	assign dst_sum  = IDX_W'(dst_prod) + IDX_W'(org_col_q) + IDX_W'(col_q);

	assign last_col = ((DIM_W+1)'(col_q) + (DIM_W+1)'(1)) >= (DIM_W+1)'(tgt_w_q);
	assign last_row = ((DIM_W+1)'(row_q) + (DIM_W+1)'(1)) >= (DIM_W+1)'(tgt_h_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			xacc_q  <= '0;
			yacc_q  <= '0;
			stepx_q <= '0;
			stepy_q <= '0;
		end else if (cmd.begin_walk) begin
			mode_q  <= mode_dec;
			col_q   <= '0;
			row_q   <= '0;
			xacc_q  <= '0;
			yacc_q  <= '0;
			stepx_q <= '0;
			stepy_q <= '0;
		end else if (div_done) begin
			stepx_q <= div_quot[0];
			stepy_q <= div_quot[1];
		end else if (cmd.emit && mode_q != MODE_IDLE) begin
			if (last_col) begin
				col_q  <= '0;
				xacc_q <= '0;
				yacc_q <= yacc_q + ACC_W'(stepy_q);
				row_q  <= row_q + 1'b1;
				if (last_row) begin
					mode_q <= MODE_IDLE;
				end
			end else begin
				col_q  <= col_q + 1'b1;
				xacc_q <= xacc_q + ACC_W'(stepx_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (mode_q == MODE_IDLE) begin
				pix_q     <= 1'b0;
				src_idx_q <= '0;
				dst_idx_q <= '0;
				rend_q    <= 1'b0;
				fend_q    <= 1'b0;
			end else begin
				pix_q     <= 1'b1;
				src_idx_q <= src_sum;
				dst_idx_q <= dst_sum;
				rend_q    <= last_col;
				fend_q    <= last_col && last_row;
			end
		end
	end

	assign pixel_valid  = pix_q;
	assign source_index = src_idx_q;
	assign dest_index   = dst_idx_q;
	assign row_end      = rend_q;
	assign frame_end    = fend_q;
endmodule

@@ hw/rtl/nnsa_ctrl.sv @@
module nnsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_restart,
	output logic           req_ready,
	input  logic           res_ready,
	output logic           res_valid,
	input  nnsa_pkg::sts_t sts,
	output nnsa_pkg::cmd_t cmd
);
	import nnsa_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        res_valid_q;
	logic        out_free;

	assign out_free = !res_valid_q || res_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (req_restart && sts.scale_req) ? ST_DIV : ST_EMIT;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready      = 1'b0;
		cmd.begin_walk = 1'b0;
		cmd.div_start  = 1'b0;
		cmd.emit       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready      = 1'b1;
				cmd.begin_walk = req_valid && req_restart;
				cmd.div_start  = req_valid && req_restart && sts.scale_req;
			end
			ST_DIV: begin
			end
			ST_EMIT: begin
				cmd.emit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
endmodule
